/* src/svm_pkg.sv */
// Shared opcodes, defaults, divider request type and ALU function of the stack VM unit.
package svm_pkg;

  localparam int DEF_STACK_DEPTH  = 256;
  localparam int DEF_MAX_FRAMES   = 100;
  localparam int DEF_GLOBAL_COUNT = 256;

  localparam int DATA_W = 32;
  localparam int PC_W   = 16;

  localparam logic [15:0] LOOP_LIMIT_RST = 16'd10000;

  localparam logic [5:0] OP_START  = 6'd0;
  localparam logic [5:0] OP_POP    = 6'd1;
  localparam logic [5:0] OP_DUP    = 6'd2;
  localparam logic [5:0] OP_GLOAD  = 6'd3;
  localparam logic [5:0] OP_GSTORE = 6'd4;
  localparam logic [5:0] OP_LLOAD  = 6'd5;
  localparam logic [5:0] OP_LSTORE = 6'd6;
  localparam logic [5:0] OP_CONST  = 6'd7;
  localparam logic [5:0] OP_ADD    = 6'd8;
  localparam logic [5:0] OP_SUB    = 6'd9;
  localparam logic [5:0] OP_MUL    = 6'd10;
  localparam logic [5:0] OP_DIV    = 6'd11;
  localparam logic [5:0] OP_MOD    = 6'd12;
  localparam logic [5:0] OP_AND    = 6'd13;
  localparam logic [5:0] OP_OR     = 6'd14;
  localparam logic [5:0] OP_XOR    = 6'd15;
  localparam logic [5:0] OP_SRA    = 6'd16;
  localparam logic [5:0] OP_SHL    = 6'd17;
  localparam logic [5:0] OP_LNOT   = 6'd18;
  localparam logic [5:0] OP_LAND   = 6'd19;
  localparam logic [5:0] OP_LOR    = 6'd20;
  localparam logic [5:0] OP_LT     = 6'd21;
  localparam logic [5:0] OP_LE     = 6'd22;
  localparam logic [5:0] OP_GT     = 6'd23;
  localparam logic [5:0] OP_GE     = 6'd24;
  localparam logic [5:0] OP_EQ     = 6'd25;
  localparam logic [5:0] OP_NE     = 6'd26;
  localparam logic [5:0] OP_NEG    = 6'd27;
  localparam logic [5:0] OP_NOT    = 6'd28;
  localparam logic [5:0] OP_JZ     = 6'd29;
  localparam logic [5:0] OP_JNZ    = 6'd30;
  localparam logic [5:0] OP_JMP    = 6'd31;
  localparam logic [5:0] OP_LJZ    = 6'd32;
  localparam logic [5:0] OP_LJNZ   = 6'd33;
  localparam logic [5:0] OP_LJMP   = 6'd34;
  localparam logic [5:0] OP_CALLV  = 6'd35;
  localparam logic [5:0] OP_CALLI  = 6'd36;
  localparam logic [5:0] OP_RETI   = 6'd37;
  localparam logic [5:0] OP_RETV   = 6'd38;
  localparam logic [5:0] OP_LOOP   = 6'd39;

  typedef struct packed {
    logic              start;
    logic              is_mod;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
  } div_req_t;

  // combinational binary ops; divide and modulo go to the divider
  function automatic logic [DATA_W-1:0] alu_fn(input logic [5:0] op,
                                               input logic [DATA_W-1:0] a,
                                               input logic [DATA_W-1:0] b);
    logic [DATA_W-1:0] r;
    r = '0;
    case (op)
      OP_ADD:  r = a + b;
      OP_SUB:  r = a - b;
      OP_MUL:  r = a * b;
      OP_AND:  r = a & b;
      OP_OR:   r = a | b;
      OP_XOR:  r = a ^ b;
      OP_SRA:  r = $unsigned($signed(a) >>> b[4:0]);
      OP_SHL:  r = a << b[4:0];
      OP_LAND: r = DATA_W'((a != '0) && (b != '0));
      OP_LOR:  r = DATA_W'((a != '0) || (b != '0));
      OP_LT:   r = DATA_W'($signed(a) <  $signed(b));
      OP_LE:   r = DATA_W'($signed(a) <= $signed(b));
      OP_GT:   r = DATA_W'($signed(a) >  $signed(b));
      OP_GE:   r = DATA_W'($signed(a) >= $signed(b));
      OP_EQ:   r = DATA_W'(a == b);
      OP_NE:   r = DATA_W'(a != b);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* src/svm_stack_ram.sv */
// Value stack memory: one write port, two registered read ports.
module svm_stack_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] ra0,
  input  logic [$clog2(DEPTH)-1:0] ra1,
  output logic [WIDTH-1:0]         rd0,
  output logic [WIDTH-1:0]         rd1,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wa,
  input  logic [WIDTH-1:0]         wd
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd0 <= mem[ra0];
      rd1 <= mem[ra1];
    end
  end

endmodule

/* src/svm_frame_ram.sv */
// Frame stack memory: saved pc, sp and bp per call level.
module svm_frame_ram #(
  parameter int DEPTH = 100,
  parameter int WIDTH = 34
) (
  input  logic                     clk,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] ra,
  output logic [WIDTH-1:0]         rd,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wa,
  input  logic [WIDTH-1:0]         wd
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd <= mem[ra];
    end
  end

endmodule

/* src/svm_glob_mem.sv */
// Global word memory; per-entry valid bits make unwritten words read as zero.
module svm_glob_mem #(
  parameter int COUNT = 256
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         re,
  input  logic [((COUNT > 1) ? $clog2(COUNT) : 1)-1:0] ra,
  output logic [31:0]                                  rd,
  input  logic                                         we,
  input  logic [((COUNT > 1) ? $clog2(COUNT) : 1)-1:0] wa,
  input  logic [31:0]                                  wd
);

  logic [31:0]      mem [COUNT];
  logic [COUNT-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd <= vld[ra] ? mem[ra] : 32'd0;
    end
  end

endmodule

/* src/svm_div.sv */
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module svm_div (
  input  logic              clk,
  input  logic              rst,
  input  svm_pkg::div_req_t req,
  output logic              done,
  output logic [31:0]       result
);
  import svm_pkg::*;

  logic        busy;
  logic [5:0]  cnt;
  logic [31:0] rem;
  logic [31:0] quo;
  logic [31:0] dvs;
  logic        is_mod;
  logic        neg_q;
  logic        neg_r;
  logic [32:0] sh;
  logic [32:0] diff;

  assign sh   = {rem, quo[31]};
  assign diff = sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        if (req.b == '0) begin
          result <= '0;
          done   <= 1'b1;
        end else begin
          busy   <= 1'b1;
          cnt    <= '0;
          rem    <= '0;
          quo    <= req.a[31] ? (32'd0 - req.a) : req.a;
          dvs    <= req.b[31] ? (32'd0 - req.b) : req.b;
          is_mod <= req.is_mod;
          neg_q  <= req.a[31] ^ req.b[31];
          neg_r  <= req.a[31];
        end
      end else if (busy) begin
        if (cnt == 6'd32) begin
          // sign fix-up after the last step
          busy <= 1'b0;
          done <= 1'b1;
          if (is_mod) begin
            result <= neg_r ? (32'd0 - rem) : rem;
          end else begin
            result <= neg_q ? (32'd0 - quo) : quo;
          end
        end else begin
          cnt <= cnt + 6'd1;
          if (!diff[32]) begin
            rem <= diff[31:0];
            quo <= {quo[30:0], 1'b1};
          end else begin
            rem <= sh[31:0];
            quo <= {quo[30:0], 1'b0};
          end
        end
      end
    end
  end

endmodule

/* src/stack_vm_execute_unit_core.sv */
// Top level of the stack VM execute unit: sequencer, state registers and memories.
//
// Usage: one pre-decoded instruction word enters on the input channel (in_valid /
// in_stall) and exactly one result word leaves on the output channel (out_valid /
// out_stall). loop_limit is written through cfg_valid / cfg_ready / cfg_data; the
// port is always ready and must only be written while the unit is idle.
// Sequence: a plain instruction passes read, execute/write-back, top-of-stack read
// and output before its result register is loaded; the next word is taken once
// the sequencer is back in idle. Divide and modulo wait in the iterative divider
// before the top-of-stack read, and start and call zero their local slots (up to
// 255) there. Every instruction reads the value stack memory, may write it back,
// and reads it a second time for the new top of stack; this sequence on the
// single write port runs one instruction at a time, and no new word is taken
// until it is through.
// in_stall is low only while the sequencer idles. A finished result waits in the
// output register; a new word is accepted meanwhile and runs until its own result
// needs the output register.
// Reset (rst, synchronous): no run active, pc/sp/bp zero, globals read as zero,
// loop_limit back to 10000. No clearing pass is needed.
module stack_vm_execute_unit_core #(
  parameter int STACK_DEPTH  = svm_pkg::DEF_STACK_DEPTH,
  parameter int MAX_FRAMES   = svm_pkg::DEF_MAX_FRAMES,
  parameter int GLOBAL_COUNT = svm_pkg::DEF_GLOBAL_COUNT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [5:0]  op,
  input  logic [31:0] imm,
  input  logic [2:0]  instr_len,
  input  logic [7:0]  arg_count,
  input  logic [15:0] callee_entry,
  input  logic [7:0]  callee_locals,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] next_pc,
  output logic [31:0] top_value,
  output logic        done_res,
  output logic        halted,
  output logic        fault,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import svm_pkg::*;

  localparam int AW    = $clog2(STACK_DEPTH);
  localparam int SP_W  = $clog2(STACK_DEPTH + 1);
  localparam int LW    = ((SP_W > 8) ? SP_W : 8) + 1;
  localparam int FA_W  = $clog2(MAX_FRAMES);
  localparam int FC_W  = $clog2(MAX_FRAMES + 1);
  localparam int GA_W  = (GLOBAL_COUNT > 1) ? $clog2(GLOBAL_COUNT) : 1;
  localparam int FR_W  = PC_W + 2 * SP_W;

  localparam logic [SP_W-1:0] DEPTH_SP = SP_W'(STACK_DEPTH);
  localparam logic [LW-1:0]   DEPTH_LW = LW'(STACK_DEPTH);
  localparam logic [FC_W-1:0] MAX_FC   = FC_W'(MAX_FRAMES);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_EXEC = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_ZERO = 3'd4;
  localparam logic [2:0] S_TOP  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0] state;

  // latched instruction word
  logic [5:0]  it_op;
  logic [31:0] it_imm;
  logic [2:0]  it_len;
  logic [7:0]  it_argc;
  logic [15:0] it_entry;
  logic [7:0]  it_locs;

  // architectural state
  logic [15:0]     loop_limit;
  logic [PC_W-1:0] pc;
  logic [SP_W-1:0] sp;
  logic [SP_W-1:0] bp;
  logic [FC_W-1:0] fc;
  logic [15:0]     lc;

  // per-instruction status
  logic            st_done;
  logic            st_halt;
  logic            st_fault;
  logic [31:0]     ret_val;
  logic [SP_W-1:0] zero_ptr;
  logic [SP_W-1:0] zero_end;

  // memory ports
  logic              stk_re;
  logic [AW-1:0]     stk_ra0;
  logic [AW-1:0]     stk_ra1;
  logic [31:0]       stk_rd0;
  logic [31:0]       stk_rd1;
  logic              stk_we;
  logic [AW-1:0]     stk_wa;
  logic [31:0]       stk_wd;
  logic [31:0]       glob_rd;
  logic [FR_W-1:0]   frm_rd;
  div_req_t          div_req;
  logic              div_done;
  logic [31:0]       div_res;

  // execute-stage decisions
  logic [PC_W-1:0] ex_pc;
  logic [SP_W-1:0] ex_sp;
  logic [SP_W-1:0] ex_bp;
  logic [FC_W-1:0] ex_fc;
  logic [15:0]     ex_lc;
  logic            ex_we;
  logic [AW-1:0]   ex_wa;
  logic [31:0]     ex_wd;
  logic            ex_gwe;
  logic            ex_fwe;
  logic [FR_W-1:0] ex_fwd;
  logic            ex_fault;
  logic            ex_done;
  logic            ex_halt;
  logic [31:0]     ex_ret;
  logic            ex_div;
  logic            ex_enter;

  // common address arithmetic
  logic [PC_W-1:0] pc_after;
  logic [PC_W-1:0] jmp_target;
  logic [7:0]      idx;
  logic [LW-1:0]   loc_sum;
  logic            loc_ok;
  logic [SP_W-1:0] sp_m1;
  logic [SP_W-1:0] sp_m2;
  logic [FC_W-1:0] fc_m1;
  logic [FC_W-1:0] fc_m2;
  logic            call_bad;
  logic [SP_W-1:0] popped;
  logic            is_int;
  logic [SP_W-1:0] ent_bp;
  logic [LW-1:0]   ent_sum;
  logic            ent_over;
  logic [SP_W-1:0] ent_end;
  logic            glob_ok;

  assign pc_after   = pc + PC_W'(it_len);
  assign jmp_target = pc_after + it_imm[PC_W-1:0];
  assign idx        = it_imm[7:0];
  assign loc_sum    = LW'(bp) + LW'(idx);
  assign loc_ok     = loc_sum < DEPTH_LW;
  assign sp_m1      = sp - SP_W'(1);
  assign sp_m2      = sp - SP_W'(2);
  assign fc_m1      = fc - FC_W'(1);
  assign fc_m2      = fc - FC_W'(2);
  assign is_int     = (it_op == OP_CALLI);
  assign call_bad   = LW'(it_argc) > LW'(sp);
  assign popped     = SP_W'(LW'(sp) - LW'(it_argc));
  assign glob_ok    = 9'(idx) < 9'(GLOBAL_COUNT);

  // function entry: locals from ent_bp, cut at the stack end
  assign ent_bp   = (it_op == OP_START) ? '0 : popped;
  assign ent_sum  = LW'(ent_bp) + LW'(it_locs);
  assign ent_over = ent_sum > DEPTH_LW;
  assign ent_end  = ent_over ? DEPTH_SP : ent_sum[SP_W-1:0];

  always_comb begin
    ex_pc    = pc;
    ex_sp    = sp;
    ex_bp    = bp;
    ex_fc    = fc;
    ex_lc    = lc;
    ex_we    = 1'b0;
    ex_wa    = sp[AW-1:0];
    ex_wd    = '0;
    ex_gwe   = 1'b0;
    ex_fwe   = 1'b0;
    ex_fwd   = {pc, sp, bp};
    ex_fault = 1'b0;
    ex_done  = 1'b0;
    ex_halt  = 1'b0;
    ex_ret   = '0;
    ex_div   = 1'b0;
    ex_enter = 1'b0;
    if (it_op == OP_START) begin
      ex_lc = loop_limit;
      if (fc == '0) begin
        ex_fc = FC_W'(1);
      end else if (fc < MAX_FC) begin
        ex_fwe = 1'b1;
        ex_fc  = fc + FC_W'(1);
      end
      ex_enter = 1'b1;
    end else if (fc != '0) begin
      ex_pc = pc_after;
      case (it_op)
        OP_POP: begin
          if (sp == '0) ex_fault = 1'b1;
          else ex_sp = sp_m1;
        end
        OP_DUP: begin
          if (sp == '0 || sp >= DEPTH_SP) begin
            ex_fault = 1'b1;
          end else begin
            ex_we = 1'b1;
            ex_wd = stk_rd0;
            ex_sp = sp + SP_W'(1);
          end
        end
        OP_GLOAD, OP_LLOAD, OP_CONST: begin
          if (sp >= DEPTH_SP) begin
            ex_fault = 1'b1;
          end else begin
            ex_we = 1'b1;
            if (it_op == OP_GLOAD) ex_wd = glob_ok ? glob_rd : '0;
            else if (it_op == OP_LLOAD) ex_wd = loc_ok ? stk_rd0 : '0;
            else ex_wd = it_imm;
            ex_sp = sp + SP_W'(1);
          end
        end
        OP_GSTORE, OP_LSTORE: begin
          if (sp == '0) begin
            ex_fault = 1'b1;
          end else begin
            ex_sp = sp_m1;
            ex_wd = stk_rd0;
            if (it_op == OP_GSTORE) begin
              ex_gwe = glob_ok;
            end else begin
              ex_we = loc_ok;
              ex_wa = loc_sum[AW-1:0];
            end
          end
        end
        OP_LNOT, OP_NEG, OP_NOT: begin
          if (sp == '0) begin
            ex_fault = 1'b1;
          end else begin
            ex_we = 1'b1;
            ex_wa = sp_m1[AW-1:0];
            if (it_op == OP_LNOT) ex_wd = 32'(stk_rd0 == '0);
            else if (it_op == OP_NEG) ex_wd = 32'd0 - stk_rd0;
            else ex_wd = ~stk_rd0;
          end
        end
        OP_JMP, OP_LJMP: ex_pc = jmp_target;
        OP_JZ, OP_LJZ, OP_JNZ, OP_LJNZ: begin
          if (sp == '0) begin
            ex_fault = 1'b1;
          end else begin
            ex_sp = sp_m1;
            if ((it_op == OP_JZ || it_op == OP_LJZ) == (stk_rd0 == '0)) ex_pc = jmp_target;
          end
        end
        OP_CALLV, OP_CALLI: begin
          if (call_bad || (is_int && popped == DEPTH_SP)) begin
            ex_fault = 1'b1;
          end else if (fc < MAX_FC) begin
            ex_fwe   = 1'b1;
            ex_fwd   = {pc_after, popped + SP_W'(is_int), bp};
            ex_fc    = fc + FC_W'(1);
            ex_enter = 1'b1;
          end else begin
            // frame limit: the call is skipped
            ex_sp = popped + SP_W'(is_int);
            ex_we = is_int;
            ex_wa = popped[AW-1:0];
          end
        end
        OP_RETI, OP_RETV: begin
          if (it_op == OP_RETI && sp == '0) begin
            ex_fault = 1'b1;
          end else begin
            if (it_op == OP_RETI) begin
              ex_ret = stk_rd0;
              ex_we  = bp < DEPTH_SP;
              ex_wa  = bp[AW-1:0];
              ex_wd  = stk_rd0;
            end
            ex_fc = fc_m1;
            if (fc_m1 == '0) begin
              ex_done = 1'b1;
              ex_pc   = '0;
              ex_sp   = '0;
              ex_bp   = '0;
            end else begin
              ex_pc = frm_rd[FR_W-1 -: PC_W];
              ex_sp = frm_rd[2*SP_W-1:SP_W];
              ex_bp = frm_rd[SP_W-1:0];
            end
          end
        end
        OP_LOOP: begin
          ex_lc   = lc - 16'd1;
          ex_halt = (lc == 16'd1);
        end
        default: begin
          if (it_op inside {[OP_ADD:OP_NE]}) begin
            if (sp < SP_W'(2)) begin
              ex_fault = 1'b1;
            end else begin
              ex_sp = sp_m1;
              ex_wa = sp_m2[AW-1:0];
              if (it_op == OP_DIV || it_op == OP_MOD) begin
                ex_div = 1'b1;
              end else begin
                ex_we = 1'b1;
                ex_wd = alu_fn(it_op, stk_rd1, stk_rd0);
              end
            end
          end
        end
      endcase
    end
    if (ex_enter) begin
      ex_pc    = it_entry;
      ex_bp    = ent_bp;
      ex_sp    = ent_end;
      ex_fault = ent_over;
    end
  end

  // stack memory port steering per sequencer state
  always_comb begin
    stk_re  = (state == S_READ) || (state == S_TOP);
    stk_ra0 = (state == S_READ && it_op == OP_LLOAD) ? loc_sum[AW-1:0] : sp_m1[AW-1:0];
    stk_ra1 = sp_m2[AW-1:0];
    stk_we  = 1'b0;
    stk_wa  = ex_wa;
    stk_wd  = ex_wd;
    case (state)
      S_EXEC: stk_we = ex_we;
      S_DIV: begin
        stk_we = div_done;
        stk_wa = sp_m1[AW-1:0];
        stk_wd = div_res;
      end
      S_ZERO: begin
        stk_we = 1'b1;
        stk_wa = zero_ptr[AW-1:0];
        stk_wd = '0;
      end
      default: stk_we = 1'b0;
    endcase
  end

  assign div_req.start  = (state == S_EXEC) && ex_div;
  assign div_req.is_mod = (it_op == OP_MOD);
  assign div_req.a      = stk_rd1;
  assign div_req.b      = stk_rd0;

  svm_stack_ram #(.DEPTH(STACK_DEPTH), .WIDTH(32)) u_stack (
    .clk (clk),
    .re  (stk_re),
    .ra0 (stk_ra0),
    .ra1 (stk_ra1),
    .rd0 (stk_rd0),
    .rd1 (stk_rd1),
    .we  (stk_we),
    .wa  (stk_wa),
    .wd  (stk_wd)
  );

  svm_frame_ram #(.DEPTH(MAX_FRAMES), .WIDTH(FR_W)) u_frames (
    .clk (clk),
    .re  (state == S_READ),
    .ra  (fc_m2[FA_W-1:0]),
    .rd  (frm_rd),
    .we  ((state == S_EXEC) && ex_fwe),
    .wa  (fc_m1[FA_W-1:0]),
    .wd  (ex_fwd)
  );

  svm_glob_mem #(.COUNT(GLOBAL_COUNT)) u_globals (
    .clk (clk),
    .rst (rst),
    .re  (state == S_READ),
    .ra  (idx[GA_W-1:0]),
    .rd  (glob_rd),
    .we  ((state == S_EXEC) && ex_gwe),
    .wa  (idx[GA_W-1:0]),
    .wd  (ex_wd)
  );

  svm_div u_div (
    .clk    (clk),
    .rst    (rst),
    .req    (div_req),
    .done   (div_done),
    .result (div_res)
  );

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      it_op    <= op;
      it_imm   <= imm;
      it_len   <= instr_len;
      it_argc  <= arg_count;
      it_entry <= callee_entry;
      it_locs  <= callee_locals;
    end
    if (state == S_EXEC) begin
      st_done  <= ex_done;
      st_halt  <= ex_halt;
      st_fault <= ex_fault;
      ret_val  <= ex_ret;
      zero_ptr <= ent_bp;
      zero_end <= ent_end;
    end else if (state == S_ZERO) begin
      zero_ptr <= zero_ptr + SP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      loop_limit <= LOOP_LIMIT_RST;
      pc         <= '0;
      sp         <= '0;
      bp         <= '0;
      fc         <= '0;
      lc         <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        loop_limit <= cfg_data;
      end
      // a new result word takes the register as the old one leaves
      if (state == S_OUT && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) state <= S_READ;
        end
        S_READ: state <= S_EXEC;
        S_EXEC: begin
          pc <= ex_pc;
          sp <= ex_sp;
          bp <= ex_bp;
          fc <= ex_fc;
          lc <= ex_lc;
          if (ex_div) state <= S_DIV;
          else if (ex_enter && ent_end != ent_bp) state <= S_ZERO;
          else state <= S_TOP;
        end
        S_DIV: begin
          if (div_done) state <= S_TOP;
        end
        S_ZERO: begin
          if (zero_ptr + SP_W'(1) == zero_end) state <= S_TOP;
        end
        S_TOP: state <= S_OUT;
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result word; top of stack comes from the read issued in S_TOP
  always_ff @(posedge clk) begin
    if (state == S_OUT && (!out_valid || !out_stall)) begin
      next_pc  <= pc;
      done_res <= st_done;
      halted   <= st_halt;
      fault    <= st_fault;
      if (st_done) top_value <= ret_val;
      else if (sp != '0) top_value <= stk_rd0;
      else top_value <= '0;
    end
  end

  a_sp_range: assert property (@(posedge clk) disable iff (rst) sp <= DEPTH_SP)
    else $error("stack pointer beyond stack depth");

  a_fc_range: assert property (@(posedge clk) disable iff (rst) fc <= MAX_FC)
    else $error("frame count beyond frame limit");

  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_OUT)
    else $error("result word raised outside output state");

  a_div_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished while sequencer not waiting");

endmodule
